@@ src/ncr_pkg.sv @@
// Shared widths, limits and status codes for the Newton cubic root solver.
// No dependencies; imported by ncr_mul and newton_cubic_root_solver.
package ncr_pkg;

  localparam int XW     = 32;  // estimate width
  localparam int MW     = 32;  // multiplier operand width
  localparam int SQ_W   = 55;  // x^2 >> F, sized for the smallest FRAC_BITS
  localparam int ACC_W  = 87;  // |x| * sq before scaling
  localparam int PV_W   = 64;  // p(x)
  localparam int AF_W   = 63;  // |p(x)|
  localparam int DV_W   = 58;  // p'(x)
  localparam int AD_W   = 57;  // |p'(x)|
  localparam int QW     = 40;  // update magnitude, capped below 2^40
  localparam int NX_W   = 42;  // x - delta before range check
  localparam int TOL_W  = 31;
  localparam int CNT_W  = 7;
  localparam int ST_W   = 2;
  localparam int CUBE_LIM = 62; // cube magnitude must stay below 2^62

  localparam logic [TOL_W-1:0] TOL_RESET = 31'd66;
  localparam logic [XW-1:0]    EST_MAX   = 32'h7FFF_FFFF;
  localparam logic [XW-1:0]    EST_MIN   = 32'h8000_0000;

  typedef enum logic [ST_W-1:0] {
    ST_CONV  = 2'd0,
    ST_LIMIT = 2'd1,
    ST_DZERO = 2'd2,
    ST_OVF   = 2'd3
  } status_e;

endpackage

@@ src/newton_cubic_root_solver.sv @@
// Newton-Raphson root of x^3 - 5x - 7 in signed fixed point, one item at a time.
// Each update makes three passes through the shared 32x32 multiplier plus setup,
// runs the radix-2 divider, then applies the step; at most MAX_ITERATIONS updates,
// with an early end on cube overflow, a zero derivative or a capped quotient.
// busy stays high until the result strobe, results cannot be stalled.
// Async active-low reset: idle, no strobe, tolerance back to 66.
module newton_cubic_root_solver import ncr_pkg::*; #(
  parameter int MAX_ITERATIONS = 64,
  parameter int FRAC_BITS      = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [TOL_W-1:0]       cfg_wdata_i,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [XW-1:0]   start_value_i,
  output logic                   done_o,
  output logic signed [XW-1:0]   root_o,
  output logic [CNT_W-1:0]       iteration_count_o,
  output logic [ST_W-1:0]        status_o
);

  localparam int CW = $clog2(MAX_ITERATIONS + 1);
  localparam int BW = $clog2(QW);
  localparam logic [CW-1:0]   MAX_CNT  = CW'(MAX_ITERATIONS);
  localparam logic [BW-1:0]   LAST_BIT = BW'(QW - 1);
  localparam logic [PV_W-1:0] K7       = PV_W'(7) << FRAC_BITS;
  localparam logic [DV_W-1:0] K5       = DV_W'(5) << FRAC_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;  // issue |x|*|x|
  localparam logic [3:0] S_CL   = 4'd2;  // take sq, issue |x|*sq low
  localparam logic [3:0] S_CH   = 4'd3;  // issue |x|*sq high
  localparam logic [3:0] S_AC   = 4'd4;  // accumulate high partial
  localparam logic [3:0] S_PV   = 4'd5;  // p(x), p'(x)
  localparam logic [3:0] S_SU   = 4'd6;  // magnitudes, sign
  localparam logic [3:0] S_CK   = 4'd7;  // quotient cap check
  localparam logic [3:0] S_DV   = 4'd8;  // one quotient bit per cycle
  localparam logic [3:0] S_UP   = 4'd9;  // apply step

  logic [3:0]             state_q, state_d;
  logic [TOL_W-1:0]       tol_q;
  logic [XW-1:0]          x_q, x_d;
  logic [CW-1:0]          count_q, count_d;
  logic [SQ_W-1:0]        sq_q, sq_d;
  logic [ACC_W-1:0]       acc_q, acc_d;
  logic [PV_W-1:0]        pv_q, pv_d;
  logic [DV_W-1:0]        dv_q, dv_d;
  logic [AF_W-1:0]        af_q, af_d;
  logic [AD_W-1:0]        ad_q, ad_d;
  logic                   neg_q, neg_d;
  logic [AD_W-1:0]        rem_q, rem_d;
  logic [QW-1:0]          quo_q, quo_d;
  logic [BW-1:0]          bit_q, bit_d;
  logic                   done_q, done_d;
  logic [XW-1:0]          root_q, root_d;
  logic [CNT_W-1:0]       cnt_out_q, cnt_out_d;
  status_e                status_q, status_d;

  logic [MW-1:0]          mul_a, mul_b;
  logic [2*MW-1:0]        prod;

  logic [MW-1:0]          ax;
  logic [SQ_W-1:0]        sq_next;
  logic [CUBE_LIM-1:0]    cm;
  logic                   cube_ovf;
  logic [PV_W-1:0]        x_ext, cube_mag, cube, pv_next;
  logic [DV_W-1:0]        sq_ext, dv_next;
  logic [AF_W-1:0]        r0, afs;
  logic                   cap_ovf;
  logic [AD_W:0]          trial, diff;
  logic                   ge;
  logic [NX_W-1:0]        xw, qw_ext, delta, nx;
  logic                   nx_ok;
  logic [CW-1:0]          count_inc;

  ncr_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign busy = (state_q != S_IDLE);

  // datapath terms
  assign ax       = x_q[XW-1] ? MW'(-x_q) : MW'(x_q);
  assign sq_next  = SQ_W'(prod >> FRAC_BITS);
  assign cm       = CUBE_LIM'(acc_q >> FRAC_BITS);
  assign cube_ovf = (acc_q >> (CUBE_LIM + FRAC_BITS)) != '0;
  assign x_ext    = {{(PV_W-XW){x_q[XW-1]}}, x_q};
  assign cube_mag = PV_W'(cm);
  assign cube     = x_q[XW-1] ? (~cube_mag + 1'b1) : cube_mag;
  assign pv_next  = cube - ((x_ext << 2) + x_ext) - K7;
  assign sq_ext   = DV_W'(sq_q);
  assign dv_next  = (sq_ext << 1) + sq_ext - K5;

  // af*2^F / ad reaches 2^40 exactly when af*2^F >> 40 is at least ad
  assign r0      = af_q >> (QW - FRAC_BITS);
  assign cap_ovf = r0 >= AF_W'(ad_q);
  assign afs     = af_q << FRAC_BITS;

  assign trial = {rem_q, quo_q[QW-1]};
  assign ge    = trial >= {1'b0, ad_q};
  assign diff  = trial - {1'b0, ad_q};

  assign xw     = {{(NX_W-XW){x_q[XW-1]}}, x_q};
  assign qw_ext = NX_W'(quo_q);
  assign delta  = neg_q ? (~qw_ext + 1'b1) : qw_ext;
  assign nx     = xw - delta;
  assign nx_ok  = (nx[NX_W-1:XW-1] == '0) || (nx[NX_W-1:XW-1] == '1);

  assign count_inc = count_q + 1'b1;

  always_comb begin
    state_d   = state_q;
    x_d       = x_q;
    count_d   = count_q;
    sq_d      = sq_q;
    acc_d     = acc_q;
    pv_d      = pv_q;
    dv_d      = dv_q;
    af_d      = af_q;
    ad_d      = ad_q;
    neg_d     = neg_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    bit_d     = bit_q;
    done_d    = 1'b0;
    root_d    = root_q;
    cnt_out_d = cnt_out_q;
    status_d  = status_q;
    mul_a     = ax;
    mul_b     = ax;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          x_d     = start_value_i;
          count_d = '0;
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        state_d = S_CL;
      end
      S_CL: begin
        sq_d    = sq_next;
        mul_b   = sq_next[MW-1:0];
        state_d = S_CH;
      end
      S_CH: begin
        acc_d   = ACC_W'(prod);
        mul_b   = MW'(sq_q[SQ_W-1:MW]);
        state_d = S_AC;
      end
      S_AC: begin
        acc_d   = acc_q + (ACC_W'(prod) << MW);
        state_d = S_PV;
      end
      S_PV: begin
        pv_d = pv_next;
        dv_d = dv_next;
        if (cube_ovf) begin
          done_d    = 1'b1;
          root_d    = x_q;
          cnt_out_d = CNT_W'(count_q);
          status_d  = ST_OVF;
          state_d   = S_IDLE;
        end else begin
          state_d = S_SU;
        end
      end
      S_SU: begin
        af_d  = pv_q[PV_W-1] ? AF_W'(-pv_q) : AF_W'(pv_q);
        ad_d  = dv_q[DV_W-1] ? AD_W'(-dv_q) : AD_W'(dv_q);
        neg_d = pv_q[PV_W-1] ^ dv_q[DV_W-1];
        if (dv_q == '0) begin
          done_d    = 1'b1;
          root_d    = x_q;
          cnt_out_d = CNT_W'(count_q);
          status_d  = ST_DZERO;
          state_d   = S_IDLE;
        end else begin
          state_d = S_CK;
        end
      end
      S_CK: begin
        rem_d = AD_W'(r0);
        quo_d = afs[QW-1:0];
        bit_d = '0;
        if (cap_ovf) begin
          count_d   = count_inc;
          done_d    = 1'b1;
          root_d    = neg_q ? EST_MAX : EST_MIN;
          cnt_out_d = CNT_W'(count_inc);
          status_d  = ST_OVF;
          state_d   = S_IDLE;
        end else begin
          state_d = S_DV;
        end
      end
      S_DV: begin
        rem_d = ge ? diff[AD_W-1:0] : trial[AD_W-1:0];
        quo_d = {quo_q[QW-2:0], ge};
        bit_d = bit_q + 1'b1;
        if (bit_q == LAST_BIT) begin
          state_d = S_UP;
        end
      end
      S_UP: begin
        count_d   = count_inc;
        cnt_out_d = CNT_W'(count_inc);
        if (!nx_ok) begin
          done_d   = 1'b1;
          root_d   = nx[NX_W-1] ? EST_MIN : EST_MAX;
          status_d = ST_OVF;
          state_d  = S_IDLE;
        end else begin
          x_d    = nx[XW-1:0];
          root_d = nx[XW-1:0];
          if (quo_q < QW'(tol_q)) begin
            done_d   = 1'b1;
            status_d = ST_CONV;
            state_d  = S_IDLE;
          end else if (count_inc == MAX_CNT) begin
            done_d   = 1'b1;
            status_d = ST_LIMIT;
            state_d  = S_IDLE;
          end else begin
            state_d = S_SQ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tol_q   <= TOL_RESET;
      count_q <= '0;
      bit_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      bit_q   <= bit_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    sq_q      <= sq_d;
    acc_q     <= acc_d;
    pv_q      <= pv_d;
    dv_q      <= dv_d;
    af_q      <= af_d;
    ad_q      <= ad_d;
    neg_q     <= neg_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    root_q    <= root_d;
    cnt_out_q <= cnt_out_d;
    status_q  <= status_d;
  end

  assign done_o            = done_q;
  assign root_o            = root_q;
  assign iteration_count_o = cnt_out_q;
  assign status_o          = status_q;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && $past(busy))
    else $error("result strobe outside end of an item");

  a_limit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_LIMIT) |-> iteration_count_o == CNT_W'(MAX_ITERATIONS))
    else $error("limit status with wrong update count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> count_q <= MAX_CNT)
    else $error("update count past limit");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DV) |-> rem_q < ad_q)
    else $error("divider remainder not below divisor");
`endif

endmodule

@@ src/ncr_mul.sv @@
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on ncr_pkg for the operand width.
module ncr_mul import ncr_pkg::*; (
  input  logic            clk_i,
  input  logic [MW-1:0]   a_i,
  input  logic [MW-1:0]   b_i,
  output logic [2*MW-1:0] p_o
);

  logic [2*MW-1:0] p_d, p_q;

  assign p_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule
